// ===== src/lcg48_bounded_random_top_defines.svh =====
// Assertion macros for the lcg48 bounded random block.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef LCG48_BOUNDED_RANDOM_TOP_DEFINES_SVH
`define LCG48_BOUNDED_RANDOM_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication: when a holds, c holds.
`define LCG48BR_ASSERT_THEN(label, a, c) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("lcg48br assertion failed");
// Next-cycle implication: when a holds, c holds in the next cycle.
`define LCG48BR_ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("lcg48br assertion failed");
`else
`define LCG48BR_ASSERT_THEN(label, a, c)
`define LCG48BR_ASSERT_NEXT(label, a, c)
`endif

`endif

// ===== src/lcg48br_pkg.sv =====
`timescale 1ns / 1ps
package lcg48br_pkg;

    // Generator constants
    localparam logic [34:0] LCG_MULT = 35'h5_DEEC_E66D;
    localparam logic [47:0] LCG_INC  = 48'hB;

    // Commands
    localparam logic [1:0] CMD_RESEED = 2'd0;
    localparam logic [1:0] CMD_INT    = 2'd1;
    localparam logic [1:0] CMD_DOUBLE = 2'd2;

    // Datapath operations
    localparam logic [3:0] OP_NOP     = 4'd0;
    localparam logic [3:0] OP_LATCH   = 4'd1;
    localparam logic [3:0] OP_SEED    = 4'd2;
    localparam logic [3:0] OP_ERR     = 4'd3;
    localparam logic [3:0] OP_MUL0    = 4'd4;
    localparam logic [3:0] OP_MUL1    = 4'd5;
    localparam logic [3:0] OP_MUL2    = 4'd6;
    localparam logic [3:0] OP_SCALE   = 4'd7;
    localparam logic [3:0] OP_DIVINIT = 4'd8;
    localparam logic [3:0] OP_DIVSTEP = 4'd9;
    localparam logic [3:0] OP_SETMOD  = 4'd10;
    localparam logic [3:0] OP_HI      = 4'd11;
    localparam logic [3:0] OP_LO      = 4'd12;
    localparam logic [3:0] OP_PUSH    = 4'd13;

    // Sequencer branch conditions
    localparam logic [2:0] C_NEXT  = 3'd0; // pc + 1
    localparam logic [2:0] C_JUMP  = 3'd1; // target
    localparam logic [2:0] C_IN    = 3'd2; // pc + 1 on input accept, else hold
    localparam logic [2:0] C_DISP  = 3'd3; // multiway by command and bound
    localparam logic [2:0] C_LOOP  = 3'd4; // target while count nonzero, else pc + 1
    localparam logic [2:0] C_RETRY = 3'd5; // target on reject, else emit
    localparam logic [2:0] C_OUT   = 3'd6; // target when output free, else hold

    // Program addresses
    localparam logic [4:0] A_IDLE  = 5'd0;
    localparam logic [4:0] A_DISP  = 5'd1;
    localparam logic [4:0] A_SEED  = 5'd2;
    localparam logic [4:0] A_ERR   = 5'd3;
    localparam logic [4:0] A_P2M0  = 5'd4;
    localparam logic [4:0] A_P2M1  = 5'd5;
    localparam logic [4:0] A_P2M2  = 5'd6;
    localparam logic [4:0] A_P2SC  = 5'd7;
    localparam logic [4:0] A_MDM0  = 5'd8;
    localparam logic [4:0] A_MDM1  = 5'd9;
    localparam logic [4:0] A_MDM2  = 5'd10;
    localparam logic [4:0] A_DIVI  = 5'd11;
    localparam logic [4:0] A_DIVS  = 5'd12;
    localparam logic [4:0] A_CHK   = 5'd13;
    localparam logic [4:0] A_DHM0  = 5'd14;
    localparam logic [4:0] A_DHM1  = 5'd15;
    localparam logic [4:0] A_DHM2  = 5'd16;
    localparam logic [4:0] A_DHI   = 5'd17;
    localparam logic [4:0] A_DLM0  = 5'd18;
    localparam logic [4:0] A_DLM1  = 5'd19;
    localparam logic [4:0] A_DLM2  = 5'd20;
    localparam logic [4:0] A_DLO   = 5'd21;
    localparam logic [4:0] A_EMIT  = 5'd22;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] cond;
        logic [4:0] target;
    } t_uword;

    // Microcode ROM
    function automatic t_uword f_ucode(input logic [4:0] pc);
        t_uword w;
        w = '{op: OP_NOP, cond: C_JUMP, target: A_IDLE};
        case (pc)
            A_IDLE:  w = '{op: OP_LATCH,   cond: C_IN,    target: A_IDLE};
            A_DISP:  w = '{op: OP_NOP,     cond: C_DISP,  target: A_IDLE};
            A_SEED:  w = '{op: OP_SEED,    cond: C_JUMP,  target: A_EMIT};
            A_ERR:   w = '{op: OP_ERR,     cond: C_JUMP,  target: A_EMIT};
            A_P2M0:  w = '{op: OP_MUL0,    cond: C_NEXT,  target: A_IDLE};
            A_P2M1:  w = '{op: OP_MUL1,    cond: C_NEXT,  target: A_IDLE};
            A_P2M2:  w = '{op: OP_MUL2,    cond: C_NEXT,  target: A_IDLE};
            A_P2SC:  w = '{op: OP_SCALE,   cond: C_JUMP,  target: A_EMIT};
            A_MDM0:  w = '{op: OP_MUL0,    cond: C_NEXT,  target: A_IDLE};
            A_MDM1:  w = '{op: OP_MUL1,    cond: C_NEXT,  target: A_IDLE};
            A_MDM2:  w = '{op: OP_MUL2,    cond: C_NEXT,  target: A_IDLE};
            A_DIVI:  w = '{op: OP_DIVINIT, cond: C_NEXT,  target: A_IDLE};
            A_DIVS:  w = '{op: OP_DIVSTEP, cond: C_LOOP,  target: A_DIVS};
            A_CHK:   w = '{op: OP_SETMOD,  cond: C_RETRY, target: A_MDM0};
            A_DHM0:  w = '{op: OP_MUL0,    cond: C_NEXT,  target: A_IDLE};
            A_DHM1:  w = '{op: OP_MUL1,    cond: C_NEXT,  target: A_IDLE};
            A_DHM2:  w = '{op: OP_MUL2,    cond: C_NEXT,  target: A_IDLE};
            A_DHI:   w = '{op: OP_HI,      cond: C_NEXT,  target: A_IDLE};
            A_DLM0:  w = '{op: OP_MUL0,    cond: C_NEXT,  target: A_IDLE};
            A_DLM1:  w = '{op: OP_MUL1,    cond: C_NEXT,  target: A_IDLE};
            A_DLM2:  w = '{op: OP_MUL2,    cond: C_NEXT,  target: A_IDLE};
            A_DLO:   w = '{op: OP_LO,      cond: C_NEXT,  target: A_IDLE};
            A_EMIT:  w = '{op: OP_PUSH,    cond: C_OUT,   target: A_IDLE};
            default: w = '{op: OP_NOP,     cond: C_JUMP,  target: A_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== src/lcg48_bounded_random_top.sv =====
`timescale 1ns / 1ps
// Channel    Dir  Handshake                     Payload (low bit up)
// s_axis     in   s_axis_tvalid/s_axis_tready   tdata: seed_value[31:0], bound[63:32]
//                                               tuser: command[1:0]
// m_axis     out  m_axis_tvalid/m_axis_tready   tdata: value[52:0], zero pad[55:53]
//                                               tuser: error[0]
//
// Steps from accept: dispatch; reseed/error: seed or error; power-of-two bound: three
//   16x35 partial products, scale; double: those and a high half, again for a low half;
//   other bound per draw: the products, divider init, 31 restoring division steps,
//   rejection check, a rejected draw repeating these. All go to the emit step.
// Reset (sync, active low) clears the sequencer, output valid and LCG state.
// A stalled m_axis holds the sequencer at emit; one item in flight, the next taken at idle.
module lcg48_bounded_random_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // seed_value[31:0], bound[63:32]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // value[52:0], zero pad[55:53]
    output logic [0:0]  m_axis_tuser    // error[0]
);
    import lcg48br_pkg::*;

`include "lcg48_bounded_random_top_defines.svh"

    // Sequencer
    logic [4:0]  r_pc;
    logic [4:0]  n_pc;
    t_uword      w_uw;

    // Latched item
    logic [1:0]  r_cmd;
    logic [31:0] r_seed;
    logic [31:0] r_bound;

    // Datapath
    logic [47:0] r_state;
    logic [47:0] r_acc;
    logic [52:0] r_value;
    logic        r_err;
    logic [30:0] r_dvd;     // dividend shift register
    logic [30:0] r_rem;     // partial remainder, always below bound
    logic [30:0] r_draw;    // 31-bit draw kept for the rejection check
    logic [4:0]  r_cnt;

    // Output register
    logic        r_m_valid;
    logic [52:0] r_m_value;
    logic        r_m_err;

    logic        w_accept;
    logic        w_out_free;
    logic [15:0] w_chunk;
    logic [50:0] w_part;
    logic [30:0] w_b31;
    logic [31:0] w_rem_sh;
    logic [32:0] w_sub;
    logic [61:0] w_scale;
    logic [32:0] w_chk;
    logic        w_reject;
    logic        w_bad_bound;
    logic        w_pow2;

    assign w_uw       = f_ucode(r_pc);
    assign s_axis_tready = (r_pc == A_IDLE);
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {3'b000, r_m_value};
    assign m_axis_tuser  = r_m_err;

    // 16x35 partial product of the LCG multiply, one chunk per step
    always_comb begin
        unique case (w_uw.op)
            OP_MUL0: w_chunk = r_state[15:0];
            OP_MUL1: w_chunk = r_state[31:16];
            default: w_chunk = r_state[47:32];
        endcase
    end
    assign w_part = 51'(w_chunk) * 51'(LCG_MULT);

    assign w_b31    = r_bound[30:0];
    assign w_rem_sh = {r_rem, r_dvd[30]};
    assign w_sub    = {1'b0, w_rem_sh} - {2'b00, w_b31};
    assign w_scale  = w_b31 * r_state[47:17];

    // Reject when r - v + (b - 1) exceeds 2^31 - 1
    assign w_chk    = {2'b00, r_draw} - {2'b00, r_rem} + {2'b00, w_b31} - 33'd1;
    assign w_reject = |w_chk[32:31];

    assign w_bad_bound = (r_bound == 32'd0) || r_bound[31];
    assign w_pow2      = ((r_bound & (r_bound - 32'd1)) == 32'd0);

    // Next step
    always_comb begin
        n_pc = r_pc + 5'd1;
        unique case (w_uw.cond)
            C_NEXT:  n_pc = r_pc + 5'd1;
            C_JUMP:  n_pc = w_uw.target;
            C_IN:    n_pc = w_accept ? (r_pc + 5'd1) : r_pc;
            C_DISP: begin
                unique case (r_cmd)
                    CMD_RESEED: n_pc = A_SEED;
                    CMD_INT:    n_pc = w_bad_bound ? A_ERR : (w_pow2 ? A_P2M0 : A_MDM0);
                    CMD_DOUBLE: n_pc = A_DHM0;
                    default:    n_pc = A_EMIT;
                endcase
            end
            C_LOOP:  n_pc = (r_cnt != 5'd0) ? w_uw.target : (r_pc + 5'd1);
            C_RETRY: n_pc = w_reject ? w_uw.target : A_EMIT;
            C_OUT:   n_pc = w_out_free ? w_uw.target : r_pc;
            default: n_pc = A_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= A_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (w_uw.op == OP_PUSH && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // LCG state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= 48'd0;
        end else if (w_uw.op == OP_SEED) begin
            r_state <= {16'd0, r_seed};
        end else if (w_uw.op == OP_MUL2) begin
            r_state <= r_acc + {w_part[15:0], 32'd0};
        end
    end

    // Payload datapath
    always_ff @(posedge i_clk) begin
        unique case (w_uw.op)
            OP_LATCH: begin
                if (w_accept) begin
                    r_cmd   <= s_axis_tuser;
                    r_seed  <= s_axis_tdata[31:0];
                    r_bound <= s_axis_tdata[63:32];
                    r_value <= 53'd0;
                    r_err   <= 1'b0;
                end
            end
            OP_ERR:   r_err <= 1'b1;
            OP_MUL0:  r_acc <= LCG_INC + w_part[47:0];
            OP_MUL1:  r_acc <= r_acc + {w_part[31:0], 16'd0};
            OP_SCALE: r_value <= 53'(w_scale[61:31]);
            OP_DIVINIT: begin
                r_dvd  <= r_state[47:17];
                r_draw <= r_state[47:17];
                r_rem  <= 31'd0;
                r_cnt  <= 5'd30;
            end
            OP_DIVSTEP: begin
                r_rem <= w_sub[32] ? w_rem_sh[30:0] : w_sub[30:0];
                r_dvd <= {r_dvd[29:0], 1'b0};
                r_cnt <= r_cnt - 5'd1;
            end
            OP_SETMOD: r_value <= 53'(r_rem);
            OP_HI:     r_value[52:27] <= r_state[47:22];
            OP_LO:     r_value[26:0]  <= r_state[47:21];
            OP_PUSH: begin
                if (w_out_free) begin
                    r_m_value <= r_value;
                    r_m_err   <= r_err;
                end
            end
            default: ;
        endcase
    end

    `LCG48BR_ASSERT_NEXT(a_accept_dispatch, w_accept, r_pc == A_DISP)
    `LCG48BR_ASSERT_THEN(a_err_zero_value, r_m_valid && r_m_err, r_m_value == 53'd0)
    `LCG48BR_ASSERT_THEN(a_rem_below_bound, r_pc == A_DIVS, r_rem < w_b31)
    `LCG48BR_ASSERT_NEXT(a_push_returns_idle, (r_pc == A_EMIT) && w_out_free,
                         r_m_valid && (r_pc == A_IDLE))

endmodule
